[hdl/cnr_pkg.sv]
package cnr_pkg;

  // RAM geometry and checksum placement
  localparam int RAM_DEPTH      = 128;
  localparam int RAM_AW         = $clog2(RAM_DEPTH);
  localparam int SUM_FIRST      = 16;
  localparam int SUM_HIGH_INDEX = 46;
  localparam int SUM_LOW_INDEX  = 47;
  localparam int SUM_W          = 13;

  // clock register map
  localparam logic [7:0] CLK_SECOND  = 8'h00;
  localparam logic [7:0] CLK_MINUTE  = 8'h02;
  localparam logic [7:0] CLK_HOUR    = 8'h04;
  localparam logic [7:0] CLK_WEEKDAY = 8'h06;
  localparam logic [7:0] CLK_MDAY    = 8'h07;
  localparam logic [7:0] CLK_MONTH   = 8'h08;
  localparam logic [7:0] CLK_YEAR    = 8'h09;
  localparam logic [7:0] CLK_CENTURY = 8'h32;

  // port command codes
  typedef enum logic [1:0] {
    CMD_INDEX = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_TIME  = 2'd3
  } cmd_t;

  // which byte a store step handles
  typedef enum logic [3:0] {
    SRC_SEC,
    SRC_MIN,
    SRC_HOUR,
    SRC_WDAY,
    SRC_MDAY,
    SRC_MONTH,
    SRC_YEAR,
    SRC_CENT,
    SRC_DATA,
    SRC_SUM_HI,
    SRC_SUM_LO
  } src_t;

  // one input item, less the command
  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [4:0] month_day;
    logic [3:0] month;
    logic [7:0] years_since_1900;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted item
    logic load_index;  // accepted item is an index write
    logic rd_en;       // read the byte addressed by src
    logic wr_en;       // store the byte selected by src
    src_t src;
  } ctl_t;

  // datapath to controller and output stage
  typedef struct packed {
    logic       data_in_sum;  // latched index lies in the checksum range
    logic [7:0] rd_byte;      // data port read result
    logic       nmi;
  } sts_t;

endpackage

[hdl/cnr_dpath.sv]
module cnr_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  cnr_pkg::ctl_t  ctl,
  input  cnr_pkg::item_t item,
  output cnr_pkg::sts_t  sts
);

  localparam logic [8:0] DEPTH_C = 9'(cnr_pkg::RAM_DEPTH);
  localparam logic [8:0] FIRST_C = 9'(cnr_pkg::SUM_FIRST);
  localparam logic [8:0] HIGH_C  = 9'(cnr_pkg::SUM_HIGH_INDEX);
  localparam logic [7:0] SUM_HI_A = 8'(cnr_pkg::SUM_HIGH_INDEX);
  localparam logic [7:0] SUM_LO_A = 8'(cnr_pkg::SUM_LOW_INDEX);

  // binary 0..99 to packed BCD; tens via reciprocal multiply
  function automatic logic [7:0] bcd_of(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  t10;
    logic [6:0]  ones;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    t10  = 7'(tens) * 7'd10;
    ones = v - t10;
    return {tens, ones[3:0]};
  endfunction

  function automatic logic in_ram(input logic [7:0] a);
    return {1'b0, a} < DEPTH_C;
  endfunction

  function automatic logic in_sum(input logic [7:0] a);
    return ({1'b0, a} >= FIRST_C) && ({1'b0, a} < HIGH_C) && in_ram(a);
  endfunction

  logic [6:0]  reg_index_r;
  logic        nmi_mask_r;
  logic [cnr_pkg::SUM_W-1:0] range_sum_r, range_sum_nxt;
  logic [cnr_pkg::SUM_W-1:0] sum_hold_r;
  logic [7:0]  data_byte_r;
  logic [7:0]  bcd_sec_r, bcd_min_r, bcd_hour_r, bcd_wday_r;
  logic [7:0]  bcd_mday_r, bcd_month_r, bcd_year_r, bcd_cent_r;

  logic [7:0]  mem [cnr_pkg::RAM_DEPTH];
  logic [cnr_pkg::RAM_DEPTH-1:0] valid_r;
  logic [7:0]  rdata_r;
  logic        rvalid_r;

  logic [7:0]  addr;
  logic [7:0]  wval;
  logic [7:0]  old_byte;
  logic [cnr_pkg::RAM_AW-1:0] idx;

  logic [1:0]  cent_q;
  logic [7:0]  year_rem;

  // century split of the year count
  always_comb begin
    if (item.years_since_1900 >= 8'd200) begin
      cent_q = 2'd2;
    end else if (item.years_since_1900 >= 8'd100) begin
      cent_q = 2'd1;
    end else begin
      cent_q = 2'd0;
    end
    year_rem = item.years_since_1900 - 8'(cent_q) * 8'd100;
  end

  // address and value of the current store step
  always_comb begin
    unique case (ctl.src)
      cnr_pkg::SRC_SEC:    begin addr = cnr_pkg::CLK_SECOND;  wval = bcd_sec_r;   end
      cnr_pkg::SRC_MIN:    begin addr = cnr_pkg::CLK_MINUTE;  wval = bcd_min_r;   end
      cnr_pkg::SRC_HOUR:   begin addr = cnr_pkg::CLK_HOUR;    wval = bcd_hour_r;  end
      cnr_pkg::SRC_WDAY:   begin addr = cnr_pkg::CLK_WEEKDAY; wval = bcd_wday_r;  end
      cnr_pkg::SRC_MDAY:   begin addr = cnr_pkg::CLK_MDAY;    wval = bcd_mday_r;  end
      cnr_pkg::SRC_MONTH:  begin addr = cnr_pkg::CLK_MONTH;   wval = bcd_month_r; end
      cnr_pkg::SRC_YEAR:   begin addr = cnr_pkg::CLK_YEAR;    wval = bcd_year_r;  end
      cnr_pkg::SRC_CENT:   begin addr = cnr_pkg::CLK_CENTURY; wval = bcd_cent_r;  end
      cnr_pkg::SRC_SUM_HI: begin
        addr = SUM_HI_A;
        wval = {3'b000, sum_hold_r[12:8]};
      end
      cnr_pkg::SRC_SUM_LO: begin
        addr = SUM_LO_A;
        wval = sum_hold_r[7:0];
      end
      default: begin
        addr = {1'b0, reg_index_r};
        wval = data_byte_r;
      end
    endcase
  end

  assign idx      = addr[cnr_pkg::RAM_AW-1:0];
  assign old_byte = rvalid_r ? rdata_r : 8'h00;

  // running checksum: replace the old byte by the new one
  always_comb begin
    range_sum_nxt = range_sum_r;
    if (ctl.wr_en && in_sum(addr)) begin
      range_sum_nxt = range_sum_r - {5'b0, old_byte} + {5'b0, wval};
    end
  end

  // port state and checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_index_r <= '0;
      nmi_mask_r  <= 1'b0;
      range_sum_r <= '0;
    end else begin
      range_sum_r <= range_sum_nxt;
      if (ctl.load && ctl.load_index) begin
        reg_index_r <= item.data_byte[6:0];
        nmi_mask_r  <= item.data_byte[7];
      end
    end
  end

  // item capture and checksum snapshot
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_byte_r <= item.data_byte;
      bcd_sec_r   <= bcd_of({1'b0, item.second});
      bcd_min_r   <= bcd_of({1'b0, item.minute});
      bcd_hour_r  <= bcd_of({2'b00, item.hour});
      bcd_wday_r  <= bcd_of(7'(item.weekday) + 7'd1);
      bcd_mday_r  <= bcd_of({2'b00, item.month_day});
      bcd_month_r <= bcd_of(7'(item.month) + 7'd1);
      bcd_year_r  <= bcd_of(year_rem[6:0]);
      bcd_cent_r  <= bcd_of(7'd19 + 7'(cent_q));
    end
    if (ctl.rd_en && ctl.src == cnr_pkg::SRC_SUM_HI) begin
      sum_hold_r <= range_sum_r;
    end
  end

  // entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.wr_en && in_ram(addr)) begin
      valid_r[idx] <= 1'b1;
    end
  end

  // CMOS RAM, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en && in_ram(addr)) begin
      mem[idx] <= wval;
    end
    if (ctl.rd_en) begin
      rdata_r  <= mem[idx];
      rvalid_r <= valid_r[idx];
    end
  end

  assign sts.data_in_sum = in_sum({1'b0, reg_index_r});
  assign sts.rd_byte     = in_ram({1'b0, reg_index_r}) ? old_byte : 8'hFF;
  assign sts.nmi         = nmi_mask_r;

endmodule

[hdl/cnr_ctrl.sv]
module cnr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  cnr_pkg::cmd_t in_cmd,
  output logic          in_ready,
  input  logic          out_free,
  input  cnr_pkg::sts_t sts,
  output cnr_pkg::ctl_t ctl,
  output logic          fin,
  output logic          fin_rd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FINISH
  } state_t;

  state_t        state_r;
  cnr_pkg::src_t src_r;
  cnr_pkg::cmd_t cmd_r;
  logic          accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_ready && in_valid;

  assign ctl.load       = accept;
  assign ctl.load_index = (in_cmd == cnr_pkg::CMD_INDEX);
  assign ctl.rd_en      = (state_r == ST_READ);
  assign ctl.wr_en      = (state_r == ST_WRITE);
  assign ctl.src        = src_r;

  assign fin    = (state_r == ST_FINISH) && out_free;
  assign fin_rd = (cmd_r == cnr_pkg::CMD_READ);

  // sequencer: one read-modify-write per stored byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      src_r   <= cnr_pkg::SRC_DATA;
      cmd_r   <= cnr_pkg::CMD_INDEX;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cmd_r <= in_cmd;
            unique case (in_cmd)
              cnr_pkg::CMD_INDEX: state_r <= ST_FINISH;
              cnr_pkg::CMD_TIME: begin
                src_r   <= cnr_pkg::SRC_SEC;
                state_r <= ST_READ;
              end
              default: begin
                src_r   <= cnr_pkg::SRC_DATA;
                state_r <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: begin
          state_r <= (cmd_r == cnr_pkg::CMD_READ) ? ST_FINISH : ST_WRITE;
        end
        ST_WRITE: begin
          state_r <= ST_READ;
          unique case (src_r)
            cnr_pkg::SRC_SEC:   src_r <= cnr_pkg::SRC_MIN;
            cnr_pkg::SRC_MIN:   src_r <= cnr_pkg::SRC_HOUR;
            cnr_pkg::SRC_HOUR:  src_r <= cnr_pkg::SRC_WDAY;
            cnr_pkg::SRC_WDAY:  src_r <= cnr_pkg::SRC_MDAY;
            cnr_pkg::SRC_MDAY:  src_r <= cnr_pkg::SRC_MONTH;
            cnr_pkg::SRC_MONTH: src_r <= cnr_pkg::SRC_YEAR;
            cnr_pkg::SRC_YEAR:  src_r <= cnr_pkg::SRC_CENT;
            cnr_pkg::SRC_DATA: begin
              if (sts.data_in_sum) begin
                src_r <= cnr_pkg::SRC_SUM_HI;
              end else begin
                state_r <= ST_FINISH;
              end
            end
            cnr_pkg::SRC_SUM_HI: src_r <= cnr_pkg::SRC_SUM_LO;
            default: state_r <= ST_FINISH;
          endcase
        end
        default: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[hdl/cmos_nvram_rtc_ports_core.sv]
// PC-style CMOS RAM reached through index and data port commands, with
// checksum upkeep and binary-to-BCD clock loading. One item is taken at a
// time; each stored byte takes a read and a write on the single RAM port;
// a data write that lands in the checksum range also stores the checksum
// pair. An item's result waits for the previous result to be taken. A new
// item is accepted while one result waits in the output register. RAM
// contents read as zero until written; no clearing pass.
module cmos_nvram_rtc_ports_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // data_byte[7:0], second[13:8], minute[19:14], hour[24:20], weekday[27:25],
  // month_day[32:28], month[36:33], years_since_1900[44:37], zero[47:45]
  input  logic [47:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], nmi_masked[8], zero[15:9]
  output logic [15:0] out_tdata
);

  cnr_pkg::item_t item;
  cnr_pkg::cmd_t  in_cmd;
  cnr_pkg::ctl_t  ctl;
  cnr_pkg::sts_t  sts;
  logic           fin;
  logic           fin_rd;
  logic           out_free;
  logic           out_valid_r;
  logic [7:0]     read_data_r;
  logic           nmi_masked_r;

  // unpack the input transfer
  assign item.data_byte        = in_tdata[7:0];
  assign item.second           = in_tdata[13:8];
  assign item.minute           = in_tdata[19:14];
  assign item.hour             = in_tdata[24:20];
  assign item.weekday          = in_tdata[27:25];
  assign item.month_day        = in_tdata[32:28];
  assign item.month            = in_tdata[36:33];
  assign item.years_since_1900 = in_tdata[44:37];
  assign in_cmd                = cnr_pkg::cmd_t'(in_tuser);

  cnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_cmd),
    .in_ready (in_tready),
    .out_free (out_free),
    .sts      (sts),
    .ctl      (ctl),
    .fin      (fin),
    .fin_rd   (fin_rd)
  );

  cnr_dpath u_dpath (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (item),
    .sts   (sts)
  );

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      read_data_r  <= fin_rd ? sts.rd_byte : 8'h00;
      nmi_masked_r <= sts.nmi;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, nmi_masked_r, read_data_r};

endmodule
